FILE: rtl/sha256_pkg.sv
package sha256_pkg;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  // Byte source for a write into the block store.
  typedef enum logic [1:0] {
    SrcMsg  = 2'd0,
    SrcPad  = 2'd1,
    SrcZero = 2'd2,
    SrcLen  = 2'd3
  } byte_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      wr_en;       // write a byte at the fill position
    byte_src_e wr_src;
    logic      len_add;     // count eight more message bits
    logic      rnd_init;    // load working variables from the chain value
    logic      rnd_step;    // run one round
    logic      chain_add;   // fold working variables into the chain value
    logic      restart;     // return to the initial hash values
    logic      out_load;    // capture the chain value for output
    logic      out_shift;   // advance the output to the next word
  } sha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
    logic       rnd_last;
    logic       out_last;
  } sha_sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: rtl/sha256_datapath.sv
module sha256_datapath
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha_cmd_t    cmd_i,
  input  logic [7:0]  msg_byte_i,
  output sha_sts_t    sts_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  logic [31:0] blk_q [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [31:0] chain_q [8];
  logic [31:0] win_q [16];
  logic [31:0] va_q [8];
  logic [5:0]  rnd_q;
  logic [31:0] out_q [8];
  logic [2:0]  oidx_q;
  logic [7:0]  wr_byte;
  logic [2:0]  len_sel;
  logic [31:0] w_new, t1, t2, s0, s1, wt;

  // Byte to be written, chosen by the controller.
  assign len_sel = fill_q[2:0];
  always_comb begin
    unique case (cmd_i.wr_src)
      SrcMsg:  wr_byte = msg_byte_i;
      SrcPad:  wr_byte = PadByte;
      SrcZero: wr_byte = 8'h00;
      SrcLen:  wr_byte = bits_q[8 * (7 - len_sel) +: 8];
      default: wr_byte = 8'h00;
    endcase
  end

  // Schedule word and round function.
  always_comb begin
    s0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    w_new = s1 + win_q[9] + s0 + win_q[0];
    wt = win_q[0];
    t1 = va_q[7] + (rotr(va_q[4], 6) ^ rotr(va_q[4], 11) ^ rotr(va_q[4], 25))
       + ((va_q[4] & va_q[5]) ^ (~va_q[4] & va_q[6])) + RoundConst[rnd_q] + wt;
    t2 = (rotr(va_q[0], 2) ^ rotr(va_q[0], 13) ^ rotr(va_q[0], 22))
       + ((va_q[0] & va_q[1]) ^ (va_q[0] & va_q[2]) ^ (va_q[1] & va_q[2]));
  end

  // Block store: one byte write a cycle into sixteen big-endian words.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      blk_q[fill_q[5:2]][8 * (3 - fill_q[1:0]) +: 8] <= wr_byte;
    end
  end

  // Control counters and the chain value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      oidx_q <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= InitHash[i];
    end else begin
      if (cmd_i.wr_en) fill_q <= fill_q + 6'd1;
      if (cmd_i.len_add) bits_q <= bits_q + 64'd8;
      if (cmd_i.rnd_init) rnd_q <= '0;
      else if (cmd_i.rnd_step) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.out_load) oidx_q <= '0;
      else if (cmd_i.out_shift) oidx_q <= oidx_q + 3'd1;
      if (cmd_i.restart) begin
        bits_q <= '0;
        for (int i = 0; i < 8; i++) chain_q[i] <= InitHash[i];
      end else if (cmd_i.chain_add) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + va_q[i];
      end
    end
  end

  // Working variables, schedule window and output words.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd_init) begin
      for (int i = 0; i < 8; i++) va_q[i] <= chain_q[i];
      for (int i = 0; i < 16; i++) win_q[i] <= blk_q[i];
    end else if (cmd_i.rnd_step) begin
      va_q[0] <= t1 + t2;
      va_q[1] <= va_q[0];
      va_q[2] <= va_q[1];
      va_q[3] <= va_q[2];
      va_q[4] <= va_q[3] + t1;
      va_q[5] <= va_q[4];
      va_q[6] <= va_q[5];
      va_q[7] <= va_q[6];
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= w_new;
    end
    if (cmd_i.out_load) begin
      for (int i = 0; i < 8; i++) out_q[i] <= chain_q[i];
    end
  end

  assign sts_o.fill     = fill_q;
  assign sts_o.rnd_last = (rnd_q == 6'd63);
  assign sts_o.out_last = (oidx_q == 3'd7);
  assign digest_word_o  = out_q[oidx_q];
  assign word_index_o   = oidx_q;
  assign digest_last_o  = (oidx_q == 3'd7);

endmodule

FILE: rtl/sha256_ctrl.sv
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     has_byte_i,
  input  logic     is_last_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  sha_sts_t sts_i,
  output sha_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StInit  = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StFold  = 3'd4;
  localparam logic [2:0] StLoad  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       final_q, final_d;   // this compression is the last of the message
  logic       tail_q, tail_d;     // padding pending after this compression
  logic       spill_q, spill_d;   // pad byte landed in the length field
  logic       pad_open_q, pad_open_d;
  logic       acc;

  assign in_stall_o  = (state_q != StIdle);
  assign acc         = in_valid_i && (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  // Sequencer for byte fill, padding, rounds and word output.
  always_comb begin
    state_d = state_q;
    final_d = final_q;
    tail_d  = tail_q;
    spill_d = spill_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          tail_d = is_last_i;
          if (has_byte_i) begin
            cmd_o.wr_en = 1'b1;
            cmd_o.wr_src = SrcMsg;
            cmd_o.len_add = 1'b1;
            if (sts_i.fill == 6'd63) begin
              final_d = 1'b0;
              state_d = StInit;
            end else if (is_last_i) begin
              state_d = StPad;
            end
          end else if (is_last_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        // Pad byte first, zeros up to the length field, then the length.
        // When the pad byte spilled into the length field, zeros fill the
        // block instead and the length follows in one more block.
        cmd_o.wr_en = 1'b1;
        if (tail_q) begin
          cmd_o.wr_src = SrcPad;
          tail_d = 1'b0;
          if (sts_i.fill == 6'd63) begin
            final_d = 1'b0;
            state_d = StInit;
          end else begin
            spill_d = (sts_i.fill >= LenPos);
          end
        end else if (spill_q || sts_i.fill < LenPos) begin
          cmd_o.wr_src = SrcZero;
          if (sts_i.fill == 6'd63) begin
            final_d = 1'b0;
            spill_d = 1'b0;
            state_d = StInit;
          end
        end else begin
          cmd_o.wr_src = SrcLen;
          if (sts_i.fill == 6'd63) begin
            final_d = 1'b1;
            state_d = StInit;
          end
        end
      end
      StInit: begin
        cmd_o.rnd_init = 1'b1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.rnd_step = 1'b1;
        if (sts_i.rnd_last) state_d = StFold;
      end
      StFold: begin
        cmd_o.chain_add = 1'b1;
        if (final_q) state_d = StLoad;
        else if (tail_q || pad_open_q) state_d = StPad;
        else state_d = StIdle;
      end
      StLoad: begin
        cmd_o.out_load = 1'b1;
        cmd_o.restart = 1'b1;
        final_d = 1'b0;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) begin
          cmd_o.out_shift = 1'b1;
          if (sts_i.out_last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Padding still open: set when a message ends, cleared after its final block.
  always_comb begin
    pad_open_d = pad_open_q;
    if (acc && is_last_i) pad_open_d = 1'b1;
    else if (state_q == StLoad) pad_open_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      final_q    <= 1'b0;
      tail_q     <= 1'b0;
      spill_q    <= 1'b0;
      pad_open_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      final_q    <= final_d;
      tail_q     <= tail_d;
      spill_q    <= spill_d;
      pad_open_q <= pad_open_d;
    end
  end

  // The store is never written while rounds or output run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound || state_q == StOut) |-> !cmd_o.wr_en)
    else $error("block store written during rounds or output");
  // Rounds always follow a load of the working variables.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StInit) |=> (state_q == StRound))
    else $error("round start lost");
  // Output begins only after the chain value was captured.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == StLoad))
    else $error("digest shown without capture");

endmodule

FILE: rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher.
// The input channel carries one message byte per item: msg_byte_i, with
// has_byte_i marking a real byte and is_last_i ending the message. An item
// is taken when in_valid_i is high and in_stall_o is low.
// A plain byte is written into the block store as it is taken. Each 64th
// byte starts a compression: one load, 64 rounds on a single round unit, one
// fold into the chain. A last item writes the padding one byte a cycle up to
// the end of the block, compresses once or twice, then loads the digest.
// The digest leaves as eight words, word 0 first, one per cycle while
// out_stall_i is low; digest_last_o marks word 7. A stall holds the word.
// No item is taken until all eight words are gone; then the block is back on
// the initial hash values with an empty length.
// Reset clears the controller and the length and loads the initial hash
// values into the chain value at once; no clearing pass is needed.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  sha_cmd_t cmd;
  sha_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .has_byte_i  (has_byte_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sha256_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_byte_i    (msg_byte_i),
    .sts_o         (sts),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .digest_last_o (digest_last_o)
  );

endmodule
